### hw/rtl/ndps_pkg.sv
// ndps_pkg: shared constants, types and the sigmoid table builder for the
// neuron dot product / sigmoid block. No dependencies.
package ndps_pkg;

  // default sizes
  localparam int MAX_INPUTS_DEF      = 64;
  localparam int SIGMOID_ENTRIES_DEF = 256;

  // field and datapath widths
  localparam int DATA_W    = 16;
  localparam int INDEX_W   = 6;
  localparam int COUNT_W   = 7;
  localparam int PROD_W    = 32;
  localparam int SUM_W     = 40;
  localparam int BIASED_W  = SUM_W + 1;
  localparam int CLAMP_W   = 30;
  localparam int BIAS_SHIFT = 12;
  localparam int ACT_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int OUTQ_DEPTH = 8;

  // item modes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_VALUE  = 2'd1;

  // e^-1 in Q32
  localparam logic [63:0] EXP_M1_Q32 = 64'd1580030169;
  localparam logic [63:0] ONE_Q32    = 64'd1 << 32;

  typedef struct packed {
    logic                    valid;
    logic signed [SUM_W-1:0] sum;
  } sum_beat_t;

  typedef struct packed {
    logic [ACT_W-1:0] activation;
    logic             sum_saturated;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } act_beat_t;

  // shift-subtract division, elaboration use only
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sigmoid at the midpoint of entry i, unsigned Q0.16
  function automatic logic [ACT_W-1:0] sig_entry(int unsigned i, int unsigned entries);
    longint      d;
    longint      acc;
    logic [63:0] ad;
    logic [63:0] t;
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] en;
    logic [63:0] term;
    logic [63:0] ef;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] r;
    d    = longint'(2 * i + 1) - longint'(entries);
    ad   = (d < 0) ? 64'(-d) : 64'(d);
    t    = udiv64(ad << 35, 64'(entries));
    n    = t >> 32;
    f    = t & 64'hFFFF_FFFF;
    en   = ONE_Q32;
    term = ONE_Q32;
    acc  = longint'(ONE_Q32);
    for (longint k = 0; k < longint'(n); k++) begin
      en = (en * EXP_M1_Q32) >> 32;
    end
    for (int k = 1; k <= 14; k++) begin
      term = udiv64((term * f) >> 32, 64'(k));
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    ef = (acc < 0) ? 64'd0 : 64'(acc);
    if (ef > ONE_Q32) begin
      ef = ONE_Q32;
    end
    e   = (en * ef) >> 32;
    den = ONE_Q32 + e;
    if (d >= 0) begin
      r = udiv64((64'd1 << 48) + (den >> 1), den);
    end else begin
      r = udiv64((e << 16) + (den >> 1), den);
    end
    if (r > 64'd65535) begin
      r = 64'd65535;
    end
    return r[ACT_W-1:0];
  endfunction

endpackage

### hw/rtl/ndps_if.sv
// ndps_if: valid/ready channel interfaces for items, results and register writes
// depends on ndps_pkg for field widths
interface ndps_item_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic [ndps_pkg::INDEX_W-1:0]        weight_index;
  logic signed [ndps_pkg::DATA_W-1:0]  data_value;

  modport source (output valid, output mode, output weight_index, output data_value,
                  input ready);
  modport sink (input valid, input mode, input weight_index, input data_value,
                output ready);
endinterface

interface ndps_result_if;
  logic                          valid;
  logic                          ready;
  logic [ndps_pkg::ACT_W-1:0]    activation;
  logic                          sum_saturated;

  modport source (output valid, output activation, output sum_saturated, input ready);
  modport sink (input valid, input activation, input sum_saturated, output ready);
endinterface

interface ndps_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ndps_pkg::CFG_IDX_W-1:0]   index;
  logic [ndps_pkg::DATA_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/neuron_dot_product_sigmoid.sv
// neuron_dot_product_sigmoid: top level of a fixed-point perceptron neuron
// depends on ndps_pkg, ndps_if, ndps_mac, ndps_act, ndps_fifo
//
//   channel  role    payload                               accepted when
//   item     sink    mode, weight_index, data_value        item.valid & item.ready
//   result   source  activation, sum_saturated             result.valid & result.ready
//   cfg      sink    index, data (0 input_count, 1 bias)   cfg.valid (ready tied high)
//
// one item per cycle while item.ready is high; the accumulator closes a 40-bit loop
// a result is registered in mac s1, s2, out_sum, then act a, b, out_res, then queued
// item.ready drops only while 8 results are queued or still in the pipeline
// reset zeroes counters, accumulator and bias, sets input_count to 1; weights kept
module neuron_dot_product_sigmoid #(
  parameter int MAX_INPUTS      = ndps_pkg::MAX_INPUTS_DEF,
  parameter int SIGMOID_ENTRIES = ndps_pkg::SIGMOID_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  ndps_item_if.sink            item,
  ndps_result_if.source        result,
  ndps_cfg_if.sink             cfg
);

  // configuration registers
  logic [ndps_pkg::COUNT_W-1:0]       input_count;
  logic signed [ndps_pkg::DATA_W-1:0] bias_value;

  // handshake and pipeline links
  logic                take;
  logic                last;
  logic                reserve;
  logic                pop;
  logic                has_room;
  logic                head_valid;
  ndps_pkg::result_t   head_data;
  ndps_pkg::sum_beat_t sum_beat;
  ndps_pkg::act_beat_t act_beat;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_count <= ndps_pkg::COUNT_W'(1);
      bias_value  <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        ndps_pkg::REG_INPUT_COUNT: input_count <= cfg.data[ndps_pkg::COUNT_W-1:0];
        ndps_pkg::REG_BIAS_VALUE:  bias_value  <= cfg.data;
        default: ;
      endcase
    end
  end

  // a slot in the result queue is claimed when the closing sample is taken
  assign item.ready = has_room;
  assign take       = item.valid && item.ready;
  assign reserve    = take && (item.mode == ndps_pkg::MODE_SAMPLE) && last;

  // weight memory, sample counter, multiply and accumulate
  ndps_mac #(
    .MAX_INPUTS (MAX_INPUTS)
  ) u_mac (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .mode         (item.mode),
    .weight_index (item.weight_index),
    .data_value   (item.data_value),
    .input_count  (input_count),
    .last         (last),
    .sum_out      (sum_beat)
  );

  // bias, clamp and sigmoid lookup
  ndps_act #(
    .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
  ) u_act (
    .clk        (clk),
    .rst        (rst),
    .sum_in     (sum_beat),
    .bias_value (bias_value),
    .res_out    (act_beat)
  );

  // results wait here so the pipeline never stalls
  ndps_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .reserve    (reserve),
    .push       (act_beat.valid),
    .push_data  (act_beat.res),
    .pop        (pop),
    .has_room   (has_room),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  assign result.valid         = head_valid;
  assign result.activation    = head_data.activation;
  assign result.sum_saturated = head_data.sum_saturated;
  assign pop                  = result.valid && result.ready;

endmodule

### hw/rtl/ndps_ram.sv
// ndps_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
module ndps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/ndps_mac.sv
// ndps_mac: weight memory, sample position counter and multiply-accumulate
// depends on ndps_pkg and ndps_ram
module ndps_mac #(
  parameter int MAX_INPUTS = ndps_pkg::MAX_INPUTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               take,
  input  logic                               mode,
  input  logic [ndps_pkg::INDEX_W-1:0]       weight_index,
  input  logic signed [ndps_pkg::DATA_W-1:0] data_value,
  input  logic [ndps_pkg::COUNT_W-1:0]       input_count,
  output logic                               last,
  output ndps_pkg::sum_beat_t                sum_out
);

  localparam int PW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int CW = (PW + 1 > ndps_pkg::COUNT_W) ? PW + 1 : ndps_pkg::COUNT_W;

  logic [PW-1:0]                      pos;
  logic [CW-1:0]                      cnt_eff;
  logic [CW-1:0]                      pos_inc;
  logic                               is_sample;
  logic                               is_load;
  logic [31:0]                        widx_ext;
  logic [ndps_pkg::DATA_W-1:0]        w_rd;
  logic                               s1_valid;
  logic                               s1_last;
  logic signed [ndps_pkg::DATA_W-1:0] s1_data;
  logic                               s2_valid;
  logic                               s2_last;
  logic signed [ndps_pkg::PROD_W-1:0] prod;
  logic signed [ndps_pkg::SUM_W-1:0]  acc;
  logic signed [ndps_pkg::SUM_W-1:0]  total;
  logic                               out_valid;
  logic signed [ndps_pkg::SUM_W-1:0]  out_sum;

  assign is_sample = take && (mode == ndps_pkg::MODE_SAMPLE);
  assign is_load   = take && (mode == ndps_pkg::MODE_LOAD) && (32'(weight_index) < MAX_INPUTS);
  assign widx_ext  = 32'(weight_index);

  // zero acts as one, oversize acts as the table depth
  always_comb begin
    if (input_count == '0) begin
      cnt_eff = CW'(1);
    end else if (32'(input_count) > MAX_INPUTS) begin
      cnt_eff = CW'(MAX_INPUTS);
    end else begin
      cnt_eff = CW'(input_count);
    end
  end

  assign pos_inc = CW'(pos) + CW'(1);
  assign last    = pos_inc >= cnt_eff;

  ndps_ram #(
    .WIDTH (ndps_pkg::DATA_W),
    .DEPTH (MAX_INPUTS)
  ) u_weights (
    .clk   (clk),
    .we    (is_load),
    .waddr (widx_ext[PW-1:0]),
    .wdata (data_value),
    .raddr (pos),
    .rdata (w_rd)
  );

  assign total   = acc + ndps_pkg::SUM_W'(prod);
  assign sum_out = '{valid: out_valid, sum: out_sum};

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (is_sample) begin
        pos <= last ? '0 : pos_inc[PW-1:0];
      end
      s1_valid  <= is_sample;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid && s2_last;
      if (s2_valid) begin
        acc <= s2_last ? '0 : total;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_last <= last;
    s1_data <= data_value;
    s2_last <= s1_last;
    prod    <= $signed(w_rd) * s1_data;
    out_sum <= total;
  end

endmodule

### hw/rtl/ndps_act.sv
// ndps_act: bias add, clamp to [-8,8), table index and sigmoid lookup
// depends on ndps_pkg
module ndps_act #(
  parameter int SIGMOID_ENTRIES = ndps_pkg::SIGMOID_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ndps_pkg::sum_beat_t                sum_in,
  input  logic signed [ndps_pkg::DATA_W-1:0] bias_value,
  output ndps_pkg::act_beat_t                res_out
);

  localparam int IW = (SIGMOID_ENTRIES > 1) ? $clog2(SIGMOID_ENTRIES) : 1;
  localparam int NW = $clog2(SIGMOID_ENTRIES + 1);
  localparam int MW = ndps_pkg::CLAMP_W + NW;
  localparam int TW = ndps_pkg::BIASED_W - ndps_pkg::CLAMP_W + 1;

  logic signed [ndps_pkg::BIASED_W-1:0] biased;
  logic [TW-1:0]                        top_bits;
  logic                                 over;
  logic [ndps_pkg::CLAMP_W-1:0]         clamped;
  logic                                 a_valid;
  logic                                 a_sat;
  logic [ndps_pkg::CLAMP_W-1:0]         a_clamp;
  logic [ndps_pkg::CLAMP_W-1:0]         off;
  logic [MW-1:0]                        scaled;
  logic                                 b_valid;
  logic                                 b_sat;
  logic [IW-1:0]                        b_idx;
  logic                                 out_valid;
  ndps_pkg::result_t                    out_res;
  logic [ndps_pkg::ACT_W-1:0]           rom [SIGMOID_ENTRIES];

  for (genvar g = 0; g < SIGMOID_ENTRIES; g++) begin : g_rom
    localparam logic [ndps_pkg::ACT_W-1:0] ENTRY = ndps_pkg::sig_entry(g, SIGMOID_ENTRIES);
    assign rom[g] = ENTRY;
  end

  // bias is Q1.14, sum is Q.26
  assign biased = ndps_pkg::BIASED_W'(sum_in.sum)
                + (ndps_pkg::BIASED_W'(bias_value) <<< ndps_pkg::BIAS_SHIFT);

  // fits in the clamp range when all bits above it match its sign
  assign top_bits = biased[ndps_pkg::BIASED_W-1 -: TW];
  assign over     = (top_bits != '0) && (top_bits != '1);

  always_comb begin
    if (!over) begin
      clamped = biased[ndps_pkg::CLAMP_W-1:0];
    end else if (biased[ndps_pkg::BIASED_W-1]) begin
      clamped = {1'b1, {(ndps_pkg::CLAMP_W-1){1'b0}}};
    end else begin
      clamped = {1'b0, {(ndps_pkg::CLAMP_W-1){1'b1}}};
    end
  end

  // offset binary of the clamped sum
  assign off    = {~a_clamp[ndps_pkg::CLAMP_W-1], a_clamp[ndps_pkg::CLAMP_W-2:0]};
  assign scaled = MW'(off) * MW'(SIGMOID_ENTRIES);

  assign res_out = '{valid: out_valid, res: out_res};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      a_valid   <= sum_in.valid;
      b_valid   <= a_valid;
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_clamp               <= clamped;
    a_sat                 <= over;
    b_idx                 <= scaled[ndps_pkg::CLAMP_W +: IW];
    b_sat                 <= a_sat;
    out_res.activation    <= rom[b_idx];
    out_res.sum_saturated <= b_sat;
  end

endmodule

### hw/rtl/ndps_fifo.sv
// ndps_fifo: result queue with a credit count covering results still in flight
// depends on ndps_pkg
module ndps_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              reserve,
  input  logic              push,
  input  ndps_pkg::result_t push_data,
  input  logic              pop,
  output logic              has_room,
  output logic              head_valid,
  output ndps_pkg::result_t head_data
);

  localparam int DEPTH = ndps_pkg::OUTQ_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);

  ndps_pkg::result_t entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W:0]    occ;
  logic [PTR_W:0]    occ_next;
  logic [PTR_W:0]    pending;
  logic [PTR_W:0]    pending_next;

  always_comb begin
    unique case ({push, pop})
      2'b10:   occ_next = occ + 1'b1;
      2'b01:   occ_next = occ - 1'b1;
      default: occ_next = occ;
    endcase
    unique case ({reserve, pop})
      2'b10:   pending_next = pending + 1'b1;
      2'b01:   pending_next = pending - 1'b1;
      default: pending_next = pending;
    endcase
  end

  assign has_room   = pending < (PTR_W + 1)'(DEPTH);
  assign head_valid = occ != '0;
  assign head_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      occ     <= '0;
      pending <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      occ     <= occ_next;
      pending <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for neuron_dot_product_sigmoid, directed table then random
// depends on ndps_pkg, ndps_if and the block's rtl; predicts each activation on its own
module testbench;

  localparam int MAX_IN         = ndps_pkg::MAX_INPUTS_DEF;
  localparam int SIG_N          = ndps_pkg::SIGMOID_ENTRIES_DEF;
  localparam int RESET_CYCLES   = 7;
  localparam int SETTLE_CYCLES  = 12;     // longer than a result takes through the pipeline and queue
  localparam int TAIL_CYCLES    = 20;
  localparam int RX_HOLD_CYCLES = 300;    // long enough to fill the 8-deep result queue
  localparam int TIMEOUT_NS     = 800_000;

  typedef longint unsigned u64_t;

  localparam longint SUM_HI = (64'sd1 <<< 29) - 1;
  localparam longint SUM_LO = -(64'sd1 <<< 29);
  localparam u64_t   Q32_ONE   = 64'd1 << 32;
  localparam u64_t   E_INV_Q32 = 64'd1580030169;   // e^-1 in Q32

  // kind of a directed row
  localparam logic ROW_ITEM = 1'b0;
  localparam logic ROW_REG  = 1'b1;

  typedef struct packed {
    logic                           kind;
    logic                           mode;
    logic [ndps_pkg::INDEX_W-1:0]   addr;
    logic [ndps_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [ndps_pkg::DATA_W-1:0]    data;
    logic                           pin;       // saturation flag typed in below
    logic                           pin_sat;
  } stim_row_t;

  // directed table, walked in order from reset (count 1, bias 0)
  localparam stim_row_t DIRECTED [30] = '{
    // weight +1.0, then zero, largest and smallest sample
    '{ROW_ITEM, ndps_pkg::MODE_LOAD,   6'd0,  '0, 16'h4000, 1'b0, 1'b0},
    '{ROW_ITEM, ndps_pkg::MODE_SAMPLE, 6'd0,  '0, 16'h0000, 1'b1, 1'b0},
    '{ROW_ITEM, ndps_pkg::MODE_SAMPLE, 6'd63, '0, 16'h7FFF, 1'b1, 1'b0},
    '{ROW_ITEM, ndps_pkg::MODE_SAMPLE, 6'd0,  '0, 16'h8000, 1'b1, 1'b0},  // lands on the lower bound
    // largest weight drives the sum past both ends
    '{ROW_ITEM, ndps_pkg::MODE_LOAD,   6'd0,  '0, 16'h7FFF, 1'b0, 1'b0},
    '{ROW_ITEM, ndps_pkg::MODE_SAMPLE, 6'd0,  '0, 16'h7FFF, 1'b1, 1'b1},
    '{ROW_ITEM, ndps_pkg::MODE_SAMPLE, 6'd0,  '0, 16'h8000, 1'b1, 1'b1},
    '{ROW_ITEM, ndps_pkg::MODE_LOAD,   6'd0,  '0, 16'h8000, 1'b0, 1'b0},
    '{ROW_ITEM, ndps_pkg::MODE_SAMPLE, 6'd0,  '0, 16'h8000, 1'b1, 1'b1},
    '{ROW_ITEM, ndps_pkg::MODE_SAMPLE, 6'd0,  '0, 16'h0001, 1'b0, 1'b0},
    // bias extremes
    '{ROW_REG,  1'b0, '0, ndps_pkg::REG_BIAS_VALUE, 16'h7FFF, 1'b0, 1'b0},
    '{ROW_ITEM, ndps_pkg::MODE_LOAD,   6'd0,  '0, 16'h7FFF, 1'b0, 1'b0},
    '{ROW_ITEM, ndps_pkg::MODE_SAMPLE, 6'd0,  '0, 16'h7FFF, 1'b1, 1'b1},
    '{ROW_ITEM, ndps_pkg::MODE_LOAD,   6'd0,  '0, 16'h0000, 1'b0, 1'b0},
    '{ROW_ITEM, ndps_pkg::MODE_SAMPLE, 6'd0,  '0, 16'h1234, 1'b1, 1'b0},  // bias alone stays in range
    '{ROW_REG,  1'b0, '0, ndps_pkg::REG_BIAS_VALUE, 16'h8000, 1'b0, 1'b0},
    '{ROW_ITEM, ndps_pkg::MODE_SAMPLE, 6'd0,  '0, 16'hFFFF, 1'b1, 1'b0},
    '{ROW_REG,  1'b0, '0, ndps_pkg::REG_BIAS_VALUE, 16'h0000, 1'b0, 1'b0},
    // a count of zero behaves as one
    '{ROW_REG,  1'b0, '0, ndps_pkg::REG_INPUT_COUNT, 16'h0000, 1'b0, 1'b0},
    '{ROW_ITEM, ndps_pkg::MODE_SAMPLE, 6'd0,  '0, 16'h0001, 1'b1, 1'b0},
    // three-sample vector with a load behind the position and the count cut short
    '{ROW_REG,  1'b0, '0, ndps_pkg::REG_INPUT_COUNT, 16'h0003, 1'b0, 1'b0},
    '{ROW_ITEM, ndps_pkg::MODE_LOAD,   6'd1,  '0, 16'hFFFF, 1'b0, 1'b0},
    '{ROW_ITEM, ndps_pkg::MODE_LOAD,   6'd2,  '0, 16'h4000, 1'b0, 1'b0},
    '{ROW_ITEM, ndps_pkg::MODE_SAMPLE, 6'd0,  '0, 16'h1000, 1'b0, 1'b0},
    '{ROW_ITEM, ndps_pkg::MODE_LOAD,   6'd0,  '0, 16'h2000, 1'b0, 1'b0},
    '{ROW_ITEM, ndps_pkg::MODE_SAMPLE, 6'd0,  '0, 16'h7FFF, 1'b0, 1'b0},
    '{ROW_REG,  1'b0, '0, ndps_pkg::REG_INPUT_COUNT, 16'h0001, 1'b0, 1'b0},
    '{ROW_ITEM, ndps_pkg::MODE_SAMPLE, 6'd0,  '0, 16'h8000, 1'b0, 1'b0},
    // top weight address and alternating bit patterns
    '{ROW_ITEM, ndps_pkg::MODE_LOAD,   6'd63, '0, 16'hAAAA, 1'b0, 1'b0},
    '{ROW_ITEM, ndps_pkg::MODE_LOAD,   6'd42, '0, 16'h5555, 1'b0, 1'b0}
  };

  logic clk;
  logic rst;

  ndps_item_if   item_ch ();
  ndps_result_if result_ch ();
  ndps_cfg_if    cfg_ch ();

  neuron_dot_product_sigmoid u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // predicted block state, updated at each accepted transaction
  logic [ndps_pkg::DATA_W-1:0]       weight_mem [MAX_IN];
  bit                                weight_loaded [MAX_IN];
  logic signed [ndps_pkg::SUM_W-1:0] mac_sum;
  logic [ndps_pkg::COUNT_W-1:0]      mac_pos;
  logic [ndps_pkg::COUNT_W-1:0]      reg_count;
  logic [ndps_pkg::DATA_W-1:0]       reg_bias;
  logic [ndps_pkg::ACT_W-1:0]        sigmoid_lut [SIG_N];

  ndps_pkg::result_t pending_activations [$];
  int                mismatches;
  int                items_sent;
  int                tx_idle_pct;
  int                rx_idle_pct;
  int                hold_requests;

  // sigmoid at the midpoint of entry i, built in Q32 integer steps
  function automatic logic [ndps_pkg::ACT_W-1:0] sigmoid_point(input int unsigned i);
    longint mid_off;
    longint acc;
    u64_t   mag, t, frac, en, term, ef, e, den, r;
    mid_off = longint'(2 * i + 1) - longint'(SIG_N);
    mag  = (mid_off < 0) ? u64_t'(-mid_off) : u64_t'(mid_off);
    t    = (mag << 35) / u64_t'(SIG_N);
    frac = t & 64'hFFFF_FFFF;
    // e^-n by repeated multiply with e^-1
    en = Q32_ONE;
    for (u64_t k = 0; k < (t >> 32); k++) begin
      en = (en * E_INV_Q32) >> 32;
    end
    // e^-f by a truncated alternating series
    term = Q32_ONE;
    acc  = longint'(Q32_ONE);
    for (int k = 1; k <= 14; k++) begin
      term = ((term * frac) >> 32) / u64_t'(k);
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    ef = (acc < 0) ? 64'd0 : u64_t'(acc);
    if (ef > Q32_ONE) begin
      ef = Q32_ONE;
    end
    e   = (en * ef) >> 32;
    den = Q32_ONE + e;
    if (mid_off >= 0) begin
      r = ((64'd1 << 48) + den / 2) / den;
    end else begin
      r = ((e << 16) + den / 2) / den;
    end
    if (r > 64'd65535) begin
      r = 64'd65535;
    end
    return r[ndps_pkg::ACT_W-1:0];
  endfunction

  // one accepted item; returns 1 with the activation when a vector completes
  function automatic bit next_activation(input logic m,
                                         input logic [ndps_pkg::INDEX_W-1:0] a,
                                         input logic [ndps_pkg::DATA_W-1:0] d,
                                         output ndps_pkg::result_t res);
    int unsigned                       n;
    longint                            w;
    longint                            s;
    u64_t                              idx;
    logic signed [ndps_pkg::SUM_W-1:0] prod;
    res = '0;
    if (m == ndps_pkg::MODE_LOAD) begin
      // loads land at once, even in the middle of a vector
      if (a < MAX_IN) begin
        weight_mem[a]    = d;
        weight_loaded[a] = 1'b1;
      end
      return 1'b0;
    end
    // count of zero acts as one, above the table size as the table size
    n = (reg_count == 0) ? 1 : (reg_count > MAX_IN) ? MAX_IN : reg_count;
    w = (mac_pos < MAX_IN) ?
        longint'($signed(weight_mem[mac_pos[ndps_pkg::INDEX_W-1:0]])) : 64'sd0;
    prod    = ndps_pkg::SUM_W'(w * longint'($signed(d)));
    mac_sum = mac_sum + prod;       // wraps at 40 bits
    mac_pos = mac_pos + 1'b1;
    if (mac_pos < n) begin
      return 1'b0;
    end
    // bias is Q1.14, the sum Q.26
    s = longint'(mac_sum) + longint'($signed(reg_bias)) * 4096;
    res.sum_saturated = 1'b0;
    if (s > SUM_HI) begin
      s = SUM_HI;
      res.sum_saturated = 1'b1;
    end else if (s < SUM_LO) begin
      s = SUM_LO;
      res.sum_saturated = 1'b1;
    end
    idx = (u64_t'(s - SUM_LO) * u64_t'(SIG_N)) >> 30;
    if (idx >= SIG_N) begin
      idx = SIG_N - 1;
    end
    res.activation = sigmoid_lut[idx];
    mac_sum = '0;
    mac_pos = '0;
    return 1'b1;
  endfunction

  // mixed data: full range, small magnitudes, extremes
  function automatic logic [ndps_pkg::DATA_W-1:0] rand_word();
    int r;
    r = $urandom_range(99);
    if (r < 35) begin
      return ndps_pkg::DATA_W'($urandom);
    end
    if (r < 80) begin
      return ndps_pkg::DATA_W'($urandom_range(4095)) - 16'd2048;
    end
    case ($urandom_range(4))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  // mostly short vectors so results stay frequent, sometimes the extremes
  function automatic logic [ndps_pkg::DATA_W-1:0] rand_count_word();
    logic [ndps_pkg::COUNT_W-1:0] c;
    logic [ndps_pkg::DATA_W-1:0]  word;
    int                           r;
    r = $urandom_range(99);
    if (r < 55) begin
      c = ndps_pkg::COUNT_W'($urandom_range(4, 1));
    end else if (r < 80) begin
      c = ndps_pkg::COUNT_W'($urandom_range(16, 5));
    end else if (r < 90) begin
      case ($urandom_range(4))
        0: c = 7'd0;
        1: c = 7'd1;
        2: c = 7'd64;
        3: c = 7'd65;
        default: c = 7'd127;
      endcase
    end else begin
      c = ndps_pkg::COUNT_W'($urandom_range(127));
    end
    word = {{(ndps_pkg::DATA_W-ndps_pkg::COUNT_W){1'b0}}, c};
    // upper data bits are outside the register; toggle them now and then
    if ($urandom_range(3) == 0) begin
      word[ndps_pkg::DATA_W-1:ndps_pkg::COUNT_W] =
        (ndps_pkg::DATA_W-ndps_pkg::COUNT_W)'($urandom);
    end
    return word;
  endfunction

  // offer one item, wait for its transaction, then predict
  task automatic send_item(input logic m, input logic [ndps_pkg::INDEX_W-1:0] a,
                           input logic [ndps_pkg::DATA_W-1:0] d, input logic pin = 1'b0,
                           input logic pin_sat = 1'b0);
    ndps_pkg::result_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.mode         <= m;
    item_ch.weight_index <= a;
    item_ch.data_value   <= d;
    do @(posedge clk); while (!item_ch.ready);
    if (next_activation(m, a, d, res)) begin
      if (pin) begin
        res.sum_saturated = pin_sat;
      end
      pending_activations.insert(pending_activations.size(), res);
    end
    items_sent++;
  endtask

  // always waits for a clock edge so back-to-back calls never share a time step
  task automatic drain_results();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_activations.size() != 0);
  endtask

  // register writes only once the block has gone quiet
  task automatic write_reg(input logic [ndps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ndps_pkg::DATA_W-1:0] val);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == ndps_pkg::REG_INPUT_COUNT) begin
      reg_count = val[ndps_pkg::COUNT_W-1:0];
    end else if (idx == ndps_pkg::REG_BIAS_VALUE) begin
      reg_bias = val;
    end
  endtask

  // random vectors with loads mixed in; squeeze stalls the receiver at the start
  task automatic run_phase(input int tx_pct, input int rx_pct, input int n_items,
                           input bit squeeze);
    int first;
    int quiet;
    bit may_write;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    write_reg(ndps_pkg::REG_INPUT_COUNT, squeeze ? 16'd1 : rand_count_word());
    write_reg(ndps_pkg::REG_BIAS_VALUE, rand_word());
    quiet = squeeze ? 40 : 0;
    if (squeeze) begin
      hold_requests++;
    end
    first = items_sent;
    while (items_sent - first < n_items) begin
      // no register writes while the result queue is meant to fill up
      may_write = (items_sent - first) >= quiet;
      if (may_write && mac_pos == 0 && $urandom_range(5) == 0) begin
        write_reg(ndps_pkg::REG_INPUT_COUNT, rand_count_word());
        if ($urandom_range(1) == 1) begin
          write_reg(ndps_pkg::REG_BIAS_VALUE, rand_word());
        end
      end else if (may_write && mac_pos != 0 && $urandom_range(39) == 0) begin
        // new count mid-vector, may fall under the current position
        write_reg(ndps_pkg::REG_INPUT_COUNT, rand_count_word());
      end
      if ($urandom_range(99) < 15) begin
        send_item(ndps_pkg::MODE_LOAD, ndps_pkg::INDEX_W'($urandom), rand_word());
      end else begin
        // every weight is loaded before a sample reads it
        if (!weight_loaded[mac_pos[ndps_pkg::INDEX_W-1:0]]) begin
          send_item(ndps_pkg::MODE_LOAD, mac_pos[ndps_pkg::INDEX_W-1:0], rand_word());
        end
        send_item(ndps_pkg::MODE_SAMPLE, ndps_pkg::INDEX_W'($urandom), rand_word());
      end
    end
    // sender waits for every outstanding result before the next phase
    drain_results();
  endtask

  // result side: random ready, plus one long hold-off on request
  initial begin : result_sink
    int hold_left;
    int hold_served;
    hold_left       = 0;
    hold_served     = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = RX_HOLD_CYCLES - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    ndps_pkg::result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_activations.size() == 0) begin
        $error("unexpected result: activation %0d, sum_saturated %0b",
               result_ch.activation, result_ch.sum_saturated);
        mismatches++;
      end else begin
        want = pending_activations.pop_front();
        if (result_ch.activation !== want.activation) begin
          $error("activation mismatch: expected %0d, actual %0d",
                 want.activation, result_ch.activation);
          mismatches++;
        end
        if (result_ch.sum_saturated !== want.sum_saturated) begin
          $error("sum_saturated mismatch: expected %0b, actual %0b",
                 want.sum_saturated, result_ch.sum_saturated);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    for (int i = 0; i < SIG_N; i++) begin
      sigmoid_lut[i] = sigmoid_point(i);
    end
    for (int i = 0; i < MAX_IN; i++) begin
      weight_mem[i]    = '0;
      weight_loaded[i] = 1'b0;
    end
    mac_sum       = '0;
    mac_pos       = '0;
    reg_count     = 7'd1;
    reg_bias      = '0;
    mismatches    = 0;
    items_sent    = 0;
    hold_requests = 0;
    tx_idle_pct   = 26;
    rx_idle_pct   = 88;

    item_ch.valid        = 1'b0;
    item_ch.mode         = ndps_pkg::MODE_LOAD;
    item_ch.weight_index = '0;
    item_ch.data_value   = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = ndps_pkg::REG_INPUT_COUNT;
    cfg_ch.data          = '0;
    rst                  = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].kind == ROW_REG) begin
        write_reg(DIRECTED[r].reg_idx, DIRECTED[r].data);
      end else begin
        send_item(DIRECTED[r].mode, DIRECTED[r].addr, DIRECTED[r].data,
                  DIRECTED[r].pin, DIRECTED[r].pin_sat);
      end
    end

    run_phase(26, 88, 570, 1'b0);
    run_phase(88, 26, 570, 1'b0);
    run_phase(0, 0, 560, 1'b1);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("testbench failed");
    $finish;
  end

endmodule
